FILE: src/bpsr_pkg.sv
// bpsr_pkg: types and constants shared by the box screen rectangle block
// no dependencies; compile first
package bpsr_pkg;

	localparam int CornerW = 21;
	localparam int DiffW   = 22;
	localparam int ProdW   = 38;
	localparam int DotW    = 40;
	localparam int DenW    = 56;
	localparam int MhW     = 54;
	localparam int QW      = 22;
	localparam int PixW    = 20;
	localparam int SumW    = 23;
	localparam int NumShift = 9;

	localparam logic [2:0] REG_EYE_X   = 3'd0;
	localparam logic [2:0] REG_EYE_Y   = 3'd1;
	localparam logic [2:0] REG_EYE_Z   = 3'd2;
	localparam logic [2:0] REG_FORWARD = 3'd3;
	localparam logic [2:0] REG_RIGHT   = 3'd4;
	localparam logic [2:0] REG_UP      = 3'd5;
	localparam logic [2:0] REG_SCREEN  = 3'd6;
	localparam logic [2:0] REG_TAN     = 3'd7;

	localparam logic [25:0] SCREEN_RESET = 26'd47187200;
	localparam logic [QW-1:0] OFF_CAP = 22'd1048576;
	localparam logic signed [DotW-1:0] NEAR_Q14 = 40'sd16384;
	localparam logic signed [SumW-1:0] PIX_LIMIT = 23'sd524287;

	typedef struct packed {
		logic signed [19:0] center_x;
		logic signed [19:0] center_y;
		logic signed [19:0] center_z;
		logic [15:0]        half_width;
		logic [15:0]        half_height;
		logic [15:0]        half_depth;
	} box_t;

	typedef struct packed {
		logic               ok;
		logic signed [19:0] min_x;
		logic signed [19:0] min_y;
		logic signed [19:0] max_x;
		logic signed [19:0] max_y;
	} rect_t;

	typedef struct packed {
		logic signed [19:0] eye_x;
		logic signed [19:0] eye_y;
		logic signed [19:0] eye_z;
		logic [47:0]        fwd;
		logic [47:0]        rgt;
		logic [47:0]        up;
		logic [12:0]        w_half;
		logic [13:0]        h;
		logic [15:0]        t;
		logic               cam_on;
	} cam_t;

	typedef struct packed {
		logic signed [CornerW-1:0] x0;
		logic signed [CornerW-1:0] x1;
		logic signed [CornerW-1:0] y0;
		logic signed [CornerW-1:0] y1;
		logic signed [CornerW-1:0] z0;
		logic signed [CornerW-1:0] z1;
	} corners_t;

	typedef struct packed {
		logic v;
		logic first;
		logic last;
		logic vc;
		logic negx;
		logic negy;
		logic ovfx;
		logic ovfy;
	} side_t;

	function automatic logic signed [15:0] axis_comp(input logic [47:0] axis,
		input logic [1:0] k);
		logic signed [15:0] c;
		case (k)
			2'd0: c = axis[15:0];
			2'd1: c = axis[31:16];
			2'd2: c = axis[47:32];
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: src/bpsr_stream_if.sv
// bpsr_stream_if: valid/ready channel carrying one word of a given type
// no dependencies
interface bpsr_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/box_perspective_screen_rect.sv
// box_perspective_screen_rect: top level, screen rectangle of a projected box
// depends on bpsr_pkg, bpsr_stream_if, bpsr_cfg, bpsr_front, bpsr_back
//
// channel  dir  handshake              word
// box      in   box.valid/box.ready    bpsr_pkg::box_t
// rect     out  rect.valid/rect.ready  bpsr_pkg::rect_t
// apb      in   psel/penable/pready    64-bit register write/read
//
// the eight corners share one projection pipeline that takes a corner per
// cycle while a box is queued and the rect word is not stalled, so a new box
// enters before the last rect is out (22 divider stages)
// a 4-word queue in the front takes boxes while the back works or stalls
// a stalled rect word freezes the whole back pipeline; no clearing after reset
module box_perspective_screen_rect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	bpsr_stream_if.sink   box,
	bpsr_stream_if.source rect
);
	import bpsr_pkg::*;

	cam_t     cam;
	corners_t head;
	logic     avail, pop;

	bpsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cam     (cam)
	);

	bpsr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box),
		.pop    (pop),
		.avail  (avail),
		.head   (head)
	);

	bpsr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cam    (cam),
		.avail  (avail),
		.head   (head),
		.pop    (pop),
		.rect   (rect)
	);

endmodule

FILE: src/bpsr_cfg.sv
// bpsr_cfg: apb register file holding the camera, decoded for the datapath
// depends on bpsr_pkg
module bpsr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output bpsr_pkg::cam_t    cam
);
	import bpsr_pkg::*;

	logic [19:0] eye_x_q, eye_y_q, eye_z_q;
	logic [47:0] fwd_q, rgt_q, up_q;
	logic [25:0] screen_q;
	logic [15:0] tan_q;
	logic        wr;
	logic [2:0]  idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q  <= '0;
			eye_y_q  <= '0;
			eye_z_q  <= '0;
			fwd_q    <= '0;
			rgt_q    <= '0;
			up_q     <= '0;
			screen_q <= SCREEN_RESET;
			tan_q    <= '0;
		end else if (wr) begin
			case (idx)
				REG_EYE_X:   eye_x_q  <= pwdata[19:0];
				REG_EYE_Y:   eye_y_q  <= pwdata[19:0];
				REG_EYE_Z:   eye_z_q  <= pwdata[19:0];
				REG_FORWARD: fwd_q    <= pwdata[47:0];
				REG_RIGHT:   rgt_q    <= pwdata[47:0];
				REG_UP:      up_q     <= pwdata[47:0];
				REG_SCREEN:  screen_q <= pwdata[25:0];
				REG_TAN:     tan_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_EYE_X:   prdata = {44'd0, eye_x_q};
			REG_EYE_Y:   prdata = {44'd0, eye_y_q};
			REG_EYE_Z:   prdata = {44'd0, eye_z_q};
			REG_FORWARD: prdata = {16'd0, fwd_q};
			REG_RIGHT:   prdata = {16'd0, rgt_q};
			REG_UP:      prdata = {16'd0, up_q};
			REG_SCREEN:  prdata = {38'd0, screen_q};
			REG_TAN:     prdata = {48'd0, tan_q};
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		cam.eye_x  = eye_x_q;
		cam.eye_y  = eye_y_q;
		cam.eye_z  = eye_z_q;
		cam.fwd    = fwd_q;
		cam.rgt    = rgt_q;
		cam.up     = up_q;
		// zero field means 8192
		cam.w_half = (screen_q[12:0] == 13'd0) ? 13'd4096 : {1'b0, screen_q[12:1]};
		cam.h      = (screen_q[25:13] == 13'd0) ? 14'd8192 : {1'b0, screen_q[25:13]};
		cam.t      = tan_q;
		cam.cam_on = |tan_q[15:1];
	end

endmodule

FILE: src/bpsr_front.sv
// bpsr_front: accepts boxes, forms the corner coordinates and queues them
// depends on bpsr_pkg and bpsr_stream_if
module bpsr_front (
	input  logic                clk,
	input  logic                arst_n,
	bpsr_stream_if.sink         box,
	input  logic                pop,
	output logic                avail,
	output bpsr_pkg::corners_t  head
);
	import bpsr_pkg::*;

	localparam int Depth = 4;
	localparam int AW = $clog2(Depth);

	corners_t       mem_q [Depth];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           push;
	corners_t       cin;
	logic signed [CornerW-1:0] cx, cy, cz;

	assign box.ready = (cnt_q != (AW+1)'(Depth));
	assign push = box.valid && box.ready;
	assign avail = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_comb begin
		cx = CornerW'(box.data.center_x);
		cy = CornerW'(box.data.center_y);
		cz = CornerW'(box.data.center_z);
		cin.x0 = cx - $signed({5'd0, box.data.half_width});
		cin.x1 = cx + $signed({5'd0, box.data.half_width});
		cin.y0 = cy - $signed({5'd0, box.data.half_depth});
		cin.y1 = cy + $signed({5'd0, box.data.half_depth});
		cin.z0 = cz;
		cin.z1 = cz + $signed({4'd0, box.data.half_height, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

FILE: src/bpsr_div.sv
// bpsr_div: pipelined restoring divider, one quotient bit per stage
// depends on bpsr_pkg
module bpsr_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bpsr_pkg::DenW-1:0]    rem_in,
	input  logic [bpsr_pkg::QW-1:0]      nlo_in,
	input  logic [bpsr_pkg::DenW-1:0]    den_in,
	output logic [bpsr_pkg::QW-1:0]      q
);
	import bpsr_pkg::*;

	logic [DenW-1:0] r_q   [QW];
	logic [DenW-1:0] d_q   [QW];
	logic [QW-1:0]   n_q   [QW];
	logic [QW-1:0]   q_q   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DenW-1:0] r_i, d_i;
		logic [QW-1:0]   n_i, q_i;
		logic [DenW:0]   t;
		logic            ge;
		if (k == 0) begin : g_first
			assign r_i = rem_in;
			assign d_i = den_in;
			assign n_i = nlo_in;
			assign q_i = '0;
		end else begin : g_next
			assign r_i = r_q[k-1];
			assign d_i = d_q[k-1];
			assign n_i = n_q[k-1];
			assign q_i = q_q[k-1];
		end
		assign t = {r_i, n_i[QW-1]};
		assign ge = (t >= {1'b0, d_i});
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k] <= ge ? DenW'(t - {1'b0, d_i}) : t[DenW-1:0];
				d_q[k] <= d_i;
				n_q[k] <= {n_i[QW-2:0], 1'b0};
				q_q[k] <= {q_i[QW-2:0], ge};
			end
		end
	end

	assign q = q_q[QW-1];

endmodule

FILE: src/bpsr_back.sv
// bpsr_back: corner sequencer, projection pipeline and rectangle accumulation
// depends on bpsr_pkg, bpsr_stream_if and bpsr_div
module bpsr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bpsr_pkg::cam_t      cam,
	input  logic                avail,
	input  bpsr_pkg::corners_t  head,
	output logic                pop,
	bpsr_stream_if.source       rect
);
	import bpsr_pkg::*;

	logic       adv, issue;
	logic [2:0] cnt_q;

	// stage 1: corner minus eye
	logic v_s1, first_s1, last_s1;
	logic signed [DiffW-1:0] d_s1 [3];
	// stage 2: products
	logic v_s2, first_s2, last_s2;
	logic signed [ProdW-1:0] p_s2 [9];
	// stage 3: dot products
	logic v_s3, first_s3, last_s3;
	logic signed [DotW-1:0] zq_s3, xq_s3, yq_s3;
	// stage 4: denominator and scaled numerators
	logic v_s4, first_s4, last_s4, vc_s4, negx_s4, negy_s4;
	logic [DenW-1:0] den_s4;
	logic [MhW-1:0]  mhx_s4, mhy_s4;
	logic [DotW-1:0] magx, magy;
	// divider alignment
	side_t side_q [QW];
	side_t side_in;
	logic [QW-1:0] qdx, qdy;
	// stage 6: screen coordinates
	logic v_s6, first_s6, last_s6, vc_s6;
	logic signed [PixW-1:0] sx_s6, sy_s6;
	logic [QW-1:0] qx, qy;
	logic signed [SumW-1:0] ox, oy, sx, sy;
	// accumulation and output
	logic any_q;
	logic signed [PixW-1:0] mnx_q, mny_q, mxx_q, mxy_q;
	logic any_n;
	logic signed [PixW-1:0] mnx_n, mny_n, mxx_n, mxy_n;
	logic out_v_q;
	rect_t out_q;

	assign adv = !out_v_q || rect.ready;
	assign issue = avail && adv;
	assign pop = issue && (cnt_q == 3'd7);
	assign rect.valid = out_v_q;
	assign rect.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s6  <= 1'b0;
			for (int i = 0; i < QW; i++) begin
				side_q[i] <= '0;
			end
		end else if (adv) begin
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			side_q[0] <= side_in;
			for (int i = 1; i < QW; i++) begin
				side_q[i] <= side_q[i-1];
			end
			v_s6 <= side_q[QW-1].v;
		end
	end

	always_comb begin
		magx = xq_s3[DotW-1] ? DotW'(-xq_s3) : xq_s3;
		magy = yq_s3[DotW-1] ? DotW'(-yq_s3) : yq_s3;
	end

	always_comb begin
		side_in.v     = v_s4;
		side_in.first = first_s4;
		side_in.last  = last_s4;
		side_in.vc    = vc_s4;
		side_in.negx  = negx_s4;
		side_in.negy  = negy_s4;
		side_in.ovfx  = (DenW'(mhx_s4[MhW-1:NumShift]) >= den_s4);
		side_in.ovfy  = (DenW'(mhy_s4[MhW-1:NumShift]) >= den_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (cnt_q == 3'd0);
			last_s1  <= (cnt_q == 3'd7);
			d_s1[0]  <= DiffW'(cnt_q[2] ? head.x1 : head.x0) - DiffW'(cam.eye_x);
			d_s1[1]  <= DiffW'(cnt_q[1] ? head.y1 : head.y0) - DiffW'(cam.eye_y);
			d_s1[2]  <= DiffW'(cnt_q[0] ? head.z1 : head.z0) - DiffW'(cam.eye_z);

			first_s2 <= first_s1;
			last_s2  <= last_s1;
			for (int k = 0; k < 3; k++) begin
				p_s2[k]   <= ProdW'(d_s1[k]) * ProdW'(axis_comp(cam.fwd, 2'(k)));
				p_s2[3+k] <= ProdW'(d_s1[k]) * ProdW'(axis_comp(cam.rgt, 2'(k)));
				p_s2[6+k] <= ProdW'(d_s1[k]) * ProdW'(axis_comp(cam.up, 2'(k)));
			end

			first_s3 <= first_s2;
			last_s3  <= last_s2;
			zq_s3 <= DotW'(p_s2[0]) + DotW'(p_s2[1]) + DotW'(p_s2[2]);
			xq_s3 <= DotW'(p_s2[3]) + DotW'(p_s2[4]) + DotW'(p_s2[5]);
			yq_s3 <= DotW'(p_s2[6]) + DotW'(p_s2[7]) + DotW'(p_s2[8]);

			first_s4 <= first_s3;
			last_s4  <= last_s3;
			vc_s4    <= cam.cam_on && (zq_s3 >= NEAR_Q14);
			negx_s4  <= xq_s3[DotW-1];
			negy_s4  <= yq_s3[DotW-1];
			den_s4   <= DenW'(zq_s3[DotW-1:0]) * DenW'(cam.t);
			mhx_s4   <= MhW'(magx) * MhW'(cam.h);
			mhy_s4   <= MhW'(magy) * MhW'(cam.h);

			first_s6 <= side_q[QW-1].first;
			last_s6  <= side_q[QW-1].last;
			vc_s6    <= side_q[QW-1].vc;
			sx_s6    <= sx[PixW-1:0];
			sy_s6    <= sy[PixW-1:0];
		end
	end

	bpsr_div u_div_x (
		.clk    (clk),
		.en     (adv),
		.rem_in (DenW'(mhx_s4[MhW-1:NumShift])),
		.nlo_in ({mhx_s4[NumShift-1:0], 13'd0}),
		.den_in (den_s4),
		.q      (qdx)
	);

	bpsr_div u_div_y (
		.clk    (clk),
		.en     (adv),
		.rem_in (DenW'(mhy_s4[MhW-1:NumShift])),
		.nlo_in ({mhy_s4[NumShift-1:0], 13'd0}),
		.den_in (den_s4),
		.q      (qdy)
	);

	always_comb begin
		qx = (side_q[QW-1].ovfx || qdx > OFF_CAP) ? OFF_CAP : qdx;
		qy = (side_q[QW-1].ovfy || qdy > OFF_CAP) ? OFF_CAP : qdy;
		ox = side_q[QW-1].negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		oy = side_q[QW-1].negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		sx = $signed({10'd0, cam.w_half}) + ox;
		sy = $signed({10'd0, cam.h[13:1]}) - oy;
		if (sx > PIX_LIMIT) begin
			sx = PIX_LIMIT;
		end else if (sx < -PIX_LIMIT) begin
			sx = -PIX_LIMIT;
		end
		if (sy > PIX_LIMIT) begin
			sy = PIX_LIMIT;
		end else if (sy < -PIX_LIMIT) begin
			sy = -PIX_LIMIT;
		end
	end

	always_comb begin
		any_n = first_s6 ? 1'b0 : any_q;
		mnx_n = first_s6 ? '0 : mnx_q;
		mny_n = first_s6 ? '0 : mny_q;
		mxx_n = first_s6 ? '0 : mxx_q;
		mxy_n = first_s6 ? '0 : mxy_q;
		if (vc_s6) begin
			if (!any_n) begin
				mnx_n = sx_s6;
				mxx_n = sx_s6;
				mny_n = sy_s6;
				mxy_n = sy_s6;
			end else begin
				if (sx_s6 < mnx_n) mnx_n = sx_s6;
				if (sx_s6 > mxx_n) mxx_n = sx_s6;
				if (sy_s6 < mny_n) mny_n = sy_s6;
				if (sy_s6 > mxy_n) mxy_n = sy_s6;
			end
			any_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s6 && last_s6;
			if (v_s6) begin
				any_q <= any_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s6) begin
			mnx_q <= mnx_n;
			mny_q <= mny_n;
			mxx_q <= mxx_n;
			mxy_q <= mxy_n;
			if (last_s6) begin
				out_q.ok    <= any_n;
				out_q.min_x <= mnx_n;
				out_q.min_y <= mny_n;
				out_q.max_x <= mxx_n;
				out_q.max_y <= mxy_n;
			end
		end
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rect.valid && rect.data.ok |->
		rect.data.min_x <= rect.data.max_x && rect.data.min_y <= rect.data.max_y)
		else $error("rectangle min above max");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rect.valid && !rect.data.ok |->
		rect.data.min_x == 0 && rect.data.min_y == 0 &&
		rect.data.max_x == 0 && rect.data.max_y == 0)
		else $error("empty rectangle not zero");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		issue && cnt_q != 3'd7 |=> avail)
		else $error("queue head lost mid box");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cnt_q) && $stable(v_s6) && $stable(any_q))
		else $error("pipeline moved during stall");

endmodule
